// ===== hw/rtl/sfa_pkg.sv =====
// Shared types, codes and helpers of the segregated-fit heap allocator.
package sfa_pkg;

  // Request operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Response status codes.
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;
  localparam logic [1:0] ST_NULL = 2'd3;

  // Configuration register indexes.
  localparam logic REG_LOOKAHEAD = 1'b0;
  localparam logic REG_EXTEND    = 1'b1;

  // Register reset values.
  localparam logic [6:0]  LookaheadReset = 7'd12;
  localparam logic [12:0] ExtendReset    = 13'd170;

  // Heap layout constants.
  localparam int          NumClasses = 7;
  localparam logic [31:0] BaseAddr   = 32'd8;
  localparam logic [31:0] MinBlock   = 32'd16;
  localparam logic [31:0] BreakReset = 32'd16;

  typedef logic [2:0] cls_t;

  // One request as taken from the input channel.
  typedef struct packed {
    logic        op;
    logic [17:0] req_size;
    logic [17:0] block_addr;
  } cmd_t;

  // One response as handed to the output register.
  typedef struct packed {
    logic [1:0]  status;
    logic [17:0] addr;
  } rsp_t;

  // Configuration register values.
  typedef struct packed {
    logic [6:0]  lookahead;
    logic [12:0] extend;
  } cfg_t;

  // One memory access slot: a write and a read per cycle.
  typedef struct packed {
    logic        we;
    logic [31:0] waddr;
    logic [31:0] wdata;
    logic [31:0] raddr;
  } ram_req_t;

  // Size class of a block size.
  function automatic cls_t class_of(input logic [31:0] s);
    cls_t c;
    if (s >= 32'd16 && s <= 32'd31) c = 3'd0;
    else if (s >= 32'd32 && s <= 32'd63) c = 3'd1;
    else if (s >= 32'd64 && s <= 32'd127) c = 3'd2;
    else if (s >= 32'd128 && s <= 32'd255) c = 3'd3;
    else if (s >= 32'd256 && s <= 32'd511) c = 3'd4;
    else if (s >= 32'd512 && s <= 32'd1023) c = 3'd5;
    else c = 3'(NumClasses - 1);
    return c;
  endfunction

  // Initial heap words: padding, prologue header and footer, epilogue.
  function automatic logic [31:0] init_word(input logic [1:0] idx);
    logic [31:0] w;
    case (idx)
      2'd0:    w = 32'd0;
      2'd3:    w = 32'd1;
      default: w = 32'd9;
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/sfa_heap_ram.sv =====
// Heap word memory with byte addressing; accesses outside the heap read 0
// and writes there are dropped.
module sfa_heap_ram #(
  parameter int HEAP_WORDS = 65536
) (
  input  logic              clk,
  input  sfa_pkg::ram_req_t req,
  output logic [31:0]       rdata
);

  localparam int AW = $clog2(HEAP_WORDS);
  localparam logic [29:0] WordsLimit = 30'(HEAP_WORDS);

  logic [31:0]   mem [HEAP_WORDS];
  logic [31:0]   rd_q;
  logic          rd_ok;
  logic          w_in;
  logic          r_in;
  logic [AW-1:0] w_idx;
  logic [AW-1:0] r_idx;

  // Word index and range check of both ports.
  assign w_in  = req.waddr[31:2] < WordsLimit;
  assign r_in  = req.raddr[31:2] < WordsLimit;
  assign w_idx = req.waddr[AW+1:2];
  assign r_idx = req.raddr[AW+1:2];

  // The write port.
  always_ff @(posedge clk) begin
    if (req.we && w_in) begin
      mem[w_idx] <= req.wdata;
    end
  end

  // The registered read port.
  always_ff @(posedge clk) begin
    rd_q  <= mem[r_idx];
    rd_ok <= r_in;
  end

  assign rdata = rd_ok ? rd_q : 32'd0;

endmodule

// ===== hw/rtl/sfa_seq.sv =====
// Sequencer of the allocator: walks the free lists, splits, merges and
// relinks blocks through the single heap memory port, one access a cycle.
module sfa_seq #(
  parameter int HEAP_WORDS = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sfa_pkg::cmd_t     cmd,
  input  sfa_pkg::cfg_t     cfg,
  input  logic              fin_ok,
  output logic              idle,
  output logic              fin,
  output sfa_pkg::rsp_t     rsp,
  output sfa_pkg::ram_req_t mreq,
  input  logic [31:0]       mem_rdata
);

  localparam int WalkLimit = HEAP_WORDS / 4;
  localparam int StepW = $clog2(WalkLimit + 1);
  localparam logic [StepW-1:0] StepMax = StepW'(WalkLimit);
  localparam logic [32:0] HeapBytes = 33'(HEAP_WORDS) * 33'd4;

  typedef enum logic [6:0] {
    S_INIT, S_IDLE,
    S_FH, S_FC, S_FS, S_FN, S_TC, S_TS, S_TN,
    S_U0, S_U1, S_U2, S_U3, S_U4, S_U5,
    S_PL0, S_PL1, S_PL2, S_PL3, S_PL4, S_PL5, S_PL6, S_PL7, S_PL8, S_PL9,
    S_P0, S_P1, S_P2, S_P3,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
    S_MA0, S_MA1, S_MA2, S_MA3, S_MA4,
    S_MB0, S_MB1, S_MB2, S_MB3, S_MB4, S_MB5,
    S_MP0, S_MP1,
    S_MC0, S_MC1, S_MC2, S_MC3, S_MC4, S_MC5, S_MC6, S_MC7, S_MC8, S_MC9, S_MC10,
    S_X0, S_X1, S_X2, S_X3, S_X4,
    S_F0, S_F1, S_F2, S_F3, S_F4, S_F5,
    S_FIN
  } state_t;

  state_t state, state_next;
  state_t ul_ret, ul_ret_next;
  state_t mg_ret, mg_ret_next;

  logic [1:0]  icnt, icnt_next;
  logic [31:0] heads [sfa_pkg::NumClasses];
  logic [31:0] heads_next [sfa_pkg::NumClasses];
  logic [31:0] hb, hb_next;
  logic [31:0] bp, bp_next;
  logic [31:0] ub, ub_next;
  logic [31:0] p, p_next;
  logic [31:0] n, n_next;
  logic [31:0] pb, pb_next;
  logic [31:0] nb, nb_next;
  logic [31:0] s, s_next;
  logic [31:0] rest, rest_next;
  logic [31:0] asize, asize_next;
  logic [31:0] gap, gap_next;
  logic [31:0] best, best_next;
  logic [31:0] cur, cur_next;
  logic [31:0] pp, pp_next;
  logic [6:0]  left, left_next;
  logic [StepW-1:0] steps, steps_next;
  sfa_pkg::cls_t cls, cls_next;
  sfa_pkg::cls_t pcls, pcls_next;
  logic        pa, pa_next;
  logic [1:0]  status, status_next;
  logic [17:0] res, res_next;

  logic [31:0] d;
  logic [31:0] dsz;
  logic [31:0] nval;
  logic [18:0] req_p15;
  logic [31:0] asize_in;
  logic [31:0] want;
  logic [29:0] wsum;
  logic [31:0] grow;
  logic [32:0] break_sum;

  // Values derived from the memory read data and the request.
  assign d         = mem_rdata;
  assign dsz       = {d[31:3], 3'b000};
  assign nval      = d + sfa_pkg::BaseAddr;
  assign req_p15   = {1'b0, cmd.req_size} + 19'd15;
  assign asize_in  = (cmd.req_size <= 18'd8) ? 32'd16 : {13'd0, req_p15[18:3], 3'b000};
  assign want      = (asize > {19'd0, cfg.extend}) ? asize : {19'd0, cfg.extend};
  assign wsum      = want[31:2] + 30'd1;
  assign grow      = {wsum[29:1], 3'b000};
  assign break_sum = {1'b0, hb} + {1'b0, grow};

  assign idle = state == S_IDLE;
  assign fin  = (state == S_FIN) && fin_ok;
  assign rsp  = '{status: status, addr: res};

  // Next-state and memory access decode.
  always_comb begin
    state_next  = state;
    ul_ret_next = ul_ret;
    mg_ret_next = mg_ret;
    icnt_next   = icnt;
    heads_next  = heads;
    hb_next     = hb;
    bp_next     = bp;
    ub_next     = ub;
    p_next      = p;
    n_next      = n;
    pb_next     = pb;
    nb_next     = nb;
    s_next      = s;
    rest_next   = rest;
    asize_next  = asize;
    gap_next    = gap;
    best_next   = best;
    cur_next    = cur;
    pp_next     = pp;
    left_next   = left;
    steps_next  = steps;
    cls_next    = cls;
    pcls_next   = pcls;
    pa_next     = pa;
    status_next = status;
    res_next    = res;
    mreq        = '0;

    unique case (state)
      // Heap set-up words after reset.
      S_INIT: begin
        mreq.we    = 1'b1;
        mreq.waddr = {28'd0, icnt, 2'b00};
        mreq.wdata = sfa_pkg::init_word(icnt);
        icnt_next  = icnt + 2'd1;
        if (icnt == 2'd3) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          status_next = sfa_pkg::ST_DONE;
          res_next    = '0;
          if (cmd.op == sfa_pkg::OP_ALLOC) begin
            if (cmd.req_size == '0) begin
              status_next = sfa_pkg::ST_ZERO;
              state_next  = S_FIN;
            end else begin
              asize_next = asize_in;
              cls_next   = sfa_pkg::class_of(asize_in);
              state_next = S_FH;
            end
          end else if (cmd.block_addr == '0) begin
            status_next = sfa_pkg::ST_NULL;
            state_next  = S_FIN;
          end else begin
            bp_next    = {14'd0, cmd.block_addr};
            state_next = S_F0;
          end
        end
      end

      // First-fit search, class by class.
      S_FH: begin
        bp_next    = heads[cls];
        steps_next = '0;
        state_next = S_FC;
      end
      S_FC: begin
        if (bp == '0 || bp == sfa_pkg::BaseAddr || steps == StepMax) begin
          if (cls == 3'(sfa_pkg::NumClasses - 1)) begin
            state_next = S_X0;
          end else begin
            cls_next   = cls + 3'd1;
            state_next = S_FH;
          end
        end else begin
          mreq.raddr = bp - 32'd4;
          state_next = S_FS;
        end
      end
      S_FS: begin
        if (dsz >= asize) begin
          gap_next   = dsz - asize;
          best_next  = bp;
          cur_next   = bp;
          left_next  = cfg.lookahead;
          state_next = S_TC;
        end else begin
          mreq.raddr = bp + 32'd4;
          state_next = S_FN;
        end
      end
      S_FN: begin
        bp_next    = nval;
        steps_next = steps + 1'b1;
        state_next = S_FC;
      end

      // Look ahead along the list for a tighter fit.
      S_TC: begin
        if (left == '0 || cur == '0 || cur == sfa_pkg::BaseAddr) begin
          bp_next     = best;
          ub_next     = best;
          ul_ret_next = S_PL0;
          state_next  = S_U0;
        end else begin
          mreq.raddr = cur - 32'd4;
          state_next = S_TS;
        end
      end
      S_TS: begin
        if (dsz >= asize && (dsz - asize) < gap) begin
          gap_next  = dsz - asize;
          best_next = cur;
        end
        mreq.raddr = cur + 32'd4;
        state_next = S_TN;
      end
      S_TN: begin
        cur_next   = nval;
        left_next  = left - 7'd1;
        state_next = S_TC;
      end

      // Unlink the block at ub from its list.
      S_U0: begin
        mreq.raddr = ub;
        state_next = S_U1;
      end
      S_U1: begin
        p_next     = nval;
        mreq.raddr = ub + 32'd4;
        state_next = S_U2;
      end
      S_U2: begin
        n_next = nval;
        if (p != sfa_pkg::BaseAddr && nval != sfa_pkg::BaseAddr) begin
          mreq.we    = 1'b1;
          mreq.waddr = p + 32'd4;
          mreq.wdata = nval - sfa_pkg::BaseAddr;
          state_next = S_U3;
        end else if (p == sfa_pkg::BaseAddr && nval == sfa_pkg::BaseAddr) begin
          mreq.raddr = ub - 32'd4;
          state_next = S_U5;
        end else if (nval == sfa_pkg::BaseAddr) begin
          mreq.we    = 1'b1;
          mreq.waddr = p + 32'd4;
          state_next = ul_ret;
        end else begin
          mreq.we    = 1'b1;
          mreq.waddr = nval;
          state_next = S_U4;
        end
      end
      S_U3: begin
        mreq.we    = 1'b1;
        mreq.waddr = n;
        mreq.wdata = p - sfa_pkg::BaseAddr;
        state_next = ul_ret;
      end
      S_U4: begin
        mreq.raddr = ub - 32'd4;
        state_next = S_U5;
      end
      S_U5: begin
        heads_next[sfa_pkg::class_of(dsz)] = n;
        state_next = ul_ret;
      end

      // Mark the block allocated, splitting off a large enough remainder.
      S_PL0: begin
        res_next   = bp[17:0];
        mreq.raddr = bp - 32'd4;
        state_next = S_PL1;
      end
      S_PL1: begin
        s_next     = dsz;
        mreq.we    = 1'b1;
        mreq.waddr = bp - 32'd4;
        if (dsz >= asize && (dsz - asize) >= sfa_pkg::MinBlock) begin
          rest_next  = dsz - asize;
          mreq.wdata = asize | 32'd1;
          state_next = S_PL2;
        end else begin
          mreq.wdata = dsz | 32'd1;
          state_next = S_PL8;
        end
      end
      S_PL2: begin
        mreq.raddr = bp - 32'd4;
        state_next = S_PL3;
      end
      S_PL3: begin
        mreq.we    = 1'b1;
        mreq.waddr = bp + dsz - 32'd8;
        mreq.wdata = asize | 32'd1;
        state_next = S_PL4;
      end
      S_PL4: begin
        mreq.raddr = bp - 32'd4;
        state_next = S_PL5;
      end
      S_PL5: begin
        nb_next    = bp + dsz;
        mreq.we    = 1'b1;
        mreq.waddr = bp + dsz - 32'd4;
        mreq.wdata = rest;
        state_next = S_PL6;
      end
      S_PL6: begin
        mreq.raddr = nb - 32'd4;
        state_next = S_PL7;
      end
      S_PL7: begin
        mreq.we    = 1'b1;
        mreq.waddr = nb + dsz - 32'd8;
        mreq.wdata = rest;
        pp_next    = nb;
        pcls_next  = sfa_pkg::class_of(rest);
        state_next = S_P0;
      end
      S_PL8: begin
        mreq.raddr = bp - 32'd4;
        state_next = S_PL9;
      end
      S_PL9: begin
        mreq.we    = 1'b1;
        mreq.waddr = bp + dsz - 32'd8;
        mreq.wdata = s | 32'd1;
        state_next = S_FIN;
      end

      // Push the block at pp onto the head of list pcls.
      S_P0: begin
        mreq.we    = 1'b1;
        mreq.waddr = pp;
        state_next = (heads[pcls] == sfa_pkg::BaseAddr) ? S_P1 : S_P2;
      end
      S_P1: begin
        mreq.we           = 1'b1;
        mreq.waddr        = pp + 32'd4;
        heads_next[pcls]  = pp;
        state_next        = S_FIN;
      end
      S_P2: begin
        mreq.we    = 1'b1;
        mreq.waddr = pp + 32'd4;
        mreq.wdata = heads[pcls] - sfa_pkg::BaseAddr;
        state_next = S_P3;
      end
      S_P3: begin
        mreq.we          = 1'b1;
        mreq.waddr       = heads[pcls];
        mreq.wdata       = pp - sfa_pkg::BaseAddr;
        heads_next[pcls] = pp;
        state_next       = S_FIN;
      end

      // Coalesce with free neighbours: find both and their allocated bits.
      S_M0: begin
        mreq.raddr = bp - 32'd8;
        state_next = S_M1;
      end
      S_M1: begin
        pb_next    = bp - dsz;
        mreq.raddr = bp - 32'd4;
        state_next = S_M2;
      end
      S_M2: begin
        s_next     = dsz;
        nb_next    = bp + dsz;
        mreq.raddr = pb - 32'd4;
        state_next = S_M3;
      end
      S_M3: begin
        mreq.raddr = pb + dsz - 32'd8;
        state_next = S_M4;
      end
      S_M4: begin
        pa_next    = d[0];
        mreq.raddr = nb - 32'd4;
        state_next = S_M5;
      end
      S_M5: begin
        if (pa && d[0]) begin
          state_next = mg_ret;
        end else if (pa) begin
          ub_next     = nb;
          ul_ret_next = S_MA0;
          state_next  = S_U0;
        end else if (d[0]) begin
          ub_next     = pb;
          ul_ret_next = S_MB0;
          state_next  = S_U0;
        end else begin
          ub_next     = pb;
          ul_ret_next = S_MC0;
          state_next  = S_U0;
        end
      end

      // Merge with the next block only.
      S_MA0: begin
        mreq.raddr = bp - 32'd4;
        state_next = S_MA1;
      end
      S_MA1: begin
        mreq.raddr = bp + dsz - 32'd4;
        state_next = S_MA2;
      end
      S_MA2: begin
        s_next     = s + dsz;
        mreq.we    = 1'b1;
        mreq.waddr = bp - 32'd4;
        mreq.wdata = s + dsz;
        state_next = S_MA3;
      end
      S_MA3: begin
        mreq.raddr = bp - 32'd4;
        state_next = S_MA4;
      end
      S_MA4: begin
        mreq.we    = 1'b1;
        mreq.waddr = bp + dsz - 32'd8;
        mreq.wdata = s;
        state_next = mg_ret;
      end

      // Merge with the previous block only.
      S_MB0: begin
        mreq.raddr = bp - 32'd8;
        state_next = S_MB1;
      end
      S_MB1: begin
        mreq.raddr = bp - dsz - 32'd4;
        state_next = S_MB2;
      end
      S_MB2: begin
        s_next     = s + dsz;
        mreq.raddr = bp - 32'd4;
        state_next = S_MB3;
      end
      S_MB3: begin
        mreq.we    = 1'b1;
        mreq.waddr = bp + dsz - 32'd8;
        mreq.wdata = s;
        state_next = S_MB4;
      end
      S_MB4: begin
        mreq.raddr = bp - 32'd8;
        state_next = S_MB5;
      end
      S_MB5: begin
        mreq.we    = 1'b1;
        mreq.waddr = bp - dsz - 32'd4;
        mreq.wdata = s;
        state_next = S_MP0;
      end

      // Step the block pointer back to the previous block.
      S_MP0: begin
        mreq.raddr = bp - 32'd8;
        state_next = S_MP1;
      end
      S_MP1: begin
        bp_next    = bp - dsz;
        state_next = mg_ret;
      end

      // Merge with both neighbours.
      S_MC0: begin
        ub_next     = nb;
        ul_ret_next = S_MC1;
        state_next  = S_U0;
      end
      S_MC1: begin
        mreq.raddr = bp - 32'd8;
        state_next = S_MC2;
      end
      S_MC2: begin
        mreq.raddr = bp - dsz - 32'd4;
        state_next = S_MC3;
      end
      S_MC3: begin
        s_next     = s + dsz;
        mreq.raddr = bp - 32'd4;
        state_next = S_MC4;
      end
      S_MC4: begin
        nb_next    = bp + dsz;
        mreq.raddr = bp + dsz - 32'd4;
        state_next = S_MC5;
      end
      S_MC5: begin
        mreq.raddr = nb + dsz - 32'd8;
        state_next = S_MC6;
      end
      S_MC6: begin
        s_next     = s + dsz;
        mreq.raddr = bp - 32'd8;
        state_next = S_MC7;
      end
      S_MC7: begin
        mreq.we    = 1'b1;
        mreq.waddr = bp - dsz - 32'd4;
        mreq.wdata = s;
        state_next = S_MC8;
      end
      S_MC8: begin
        mreq.raddr = bp - 32'd4;
        state_next = S_MC9;
      end
      S_MC9: begin
        nb_next    = bp + dsz;
        mreq.raddr = bp + dsz - 32'd4;
        state_next = S_MC10;
      end
      S_MC10: begin
        mreq.we    = 1'b1;
        mreq.waddr = nb + dsz - 32'd8;
        mreq.wdata = s;
        state_next = S_MP0;
      end

      // Grow the heap by a fresh free block and a new epilogue, or report out of memory.
      S_X0: begin
        if (break_sum > HeapBytes) begin
          status_next = sfa_pkg::ST_OOM;
          state_next  = S_FIN;
        end else begin
          bp_next    = hb;
          hb_next    = break_sum[31:0];
          s_next     = grow;
          mreq.we    = 1'b1;
          mreq.waddr = hb - 32'd4;
          mreq.wdata = grow;
          state_next = S_X1;
        end
      end
      S_X1: begin
        mreq.raddr = bp - 32'd4;
        state_next = S_X2;
      end
      S_X2: begin
        mreq.we    = 1'b1;
        mreq.waddr = bp + dsz - 32'd8;
        mreq.wdata = s;
        state_next = S_X3;
      end
      S_X3: begin
        mreq.raddr = bp - 32'd4;
        state_next = S_X4;
      end
      S_X4: begin
        mreq.we     = 1'b1;
        mreq.waddr  = bp + dsz - 32'd4;
        mreq.wdata  = 32'd1;
        mg_ret_next = S_PL0;
        state_next  = S_M0;
      end

      // Release: clear the allocated bits, merge, then push.
      S_F0: begin
        mreq.raddr = bp - 32'd4;
        state_next = S_F1;
      end
      S_F1: begin
        s_next     = dsz;
        mreq.we    = 1'b1;
        mreq.waddr = bp - 32'd4;
        mreq.wdata = dsz;
        state_next = S_F2;
      end
      S_F2: begin
        mreq.raddr = bp - 32'd4;
        state_next = S_F3;
      end
      S_F3: begin
        mreq.we     = 1'b1;
        mreq.waddr  = bp + dsz - 32'd8;
        mreq.wdata  = s;
        mg_ret_next = S_F4;
        state_next  = S_M0;
      end
      S_F4: begin
        mreq.raddr = bp - 32'd4;
        state_next = S_F5;
      end
      S_F5: begin
        pp_next    = bp;
        pcls_next  = sfa_pkg::class_of(dsz);
        state_next = S_P0;
      end

      // Hand the response to the output register.
      S_FIN: begin
        if (fin_ok) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, heap bookkeeping and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_INIT;
      ul_ret <= S_IDLE;
      mg_ret <= S_IDLE;
      icnt   <= '0;
      hb     <= sfa_pkg::BreakReset;
      for (int i = 0; i < sfa_pkg::NumClasses; i++) begin
        heads[i] <= sfa_pkg::BaseAddr;
      end
    end else begin
      state  <= state_next;
      ul_ret <= ul_ret_next;
      mg_ret <= mg_ret_next;
      icnt   <= icnt_next;
      hb     <= hb_next;
      heads  <= heads_next;
    end
    bp     <= bp_next;
    ub     <= ub_next;
    p      <= p_next;
    n      <= n_next;
    pb     <= pb_next;
    nb     <= nb_next;
    s      <= s_next;
    rest   <= rest_next;
    asize  <= asize_next;
    gap    <= gap_next;
    best   <= best_next;
    cur    <= cur_next;
    pp     <= pp_next;
    left   <= left_next;
    steps  <= steps_next;
    cls    <= cls_next;
    pcls   <= pcls_next;
    pa     <= pa_next;
    status <= status_next;
    res    <= res_next;
  end

  // The memory is never written while waiting for a request.
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !mreq.we)
    else $error("memory written while idle");

  // A failed or ignored request never reports an address.
  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    fin && rsp.status != sfa_pkg::ST_DONE |-> rsp.addr == '0)
    else $error("address reported with non-success status");

  // A request is only taken in the idle state.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE)
    else $error("request taken while busy");

  // The heap break never moves backwards.
  a_break_grows: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> hb >= $past(hb))
    else $error("heap break decreased");

endmodule

// ===== hw/rtl/segregated_fit_heap_allocator_unit.sv =====
// Channel   Handshake                 Payload
// in        in_valid / in_ready       operation, req_size, block_addr
// out       out_valid / out_ready     status, addr_out
// config    psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// Each request makes one access to the single heap memory port per cycle.
// A zero-size allocate or a null free goes straight to the response; an
// allocate walks the list blocks in the search, examines blocks for a
// tighter fit and may grow the heap.
// After reset the block writes the four set-up words before ready.
// The response waits in an output register; the next request is taken once
// the response has been handed to it.
module segregated_fit_heap_allocator_unit #(
  parameter int HEAP_WORDS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [17:0] req_size,
  input  logic [17:0] block_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [17:0] addr_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sfa_pkg::cfg_t     cfg;
  sfa_pkg::cmd_t     cmd;
  sfa_pkg::rsp_t     rsp;
  sfa_pkg::ram_req_t mreq;
  logic [31:0]       mem_rdata;
  logic              idle;
  logic              fin;
  logic              fin_ok;
  logic              start;
  logic              cfg_wr;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lookahead <= sfa_pkg::LookaheadReset;
      cfg.extend    <= sfa_pkg::ExtendReset;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        sfa_pkg::REG_LOOKAHEAD: cfg.lookahead <= pwdata[6:0];
        sfa_pkg::REG_EXTEND:    cfg.extend    <= pwdata[12:0];
        default:                cfg.extend    <= cfg.extend;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      sfa_pkg::REG_LOOKAHEAD: prdata = {25'd0, cfg.lookahead};
      sfa_pkg::REG_EXTEND:    prdata = {19'd0, cfg.extend};
      default:                prdata = '0;
    endcase
  end

  // Request side.
  assign in_ready = idle;
  assign start    = in_valid && in_ready;
  assign cmd      = '{op: operation, req_size: req_size, block_addr: block_addr};

  // Output register between the sequencer and the response channel.
  assign fin_ok = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (fin) begin
      status   <= rsp.status;
      addr_out <= rsp.addr;
    end
  end

  sfa_seq #(
    .HEAP_WORDS(HEAP_WORDS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .cfg       (cfg),
    .fin_ok    (fin_ok),
    .idle      (idle),
    .fin       (fin),
    .rsp       (rsp),
    .mreq      (mreq),
    .mem_rdata (mem_rdata)
  );

  sfa_heap_ram #(
    .HEAP_WORDS(HEAP_WORDS)
  ) u_ram (
    .clk   (clk),
    .req   (mreq),
    .rdata (mem_rdata)
  );

endmodule

// ===== tb/sv/allocator_checker.sv =====
module allocator_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        operation,
  input  logic [17:0] req_size,
  input  logic [17:0] block_addr,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [17:0] addr_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);
  import sfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HeapWords = 65536;

  typedef struct packed {
    logic [1:0]  status;
    logic [17:0] addr;
  } reply_t;

  // Shadow copy of the heap, the bin heads, the break and the registers.
  logic [31:0] heap_words [int unsigned];
  logic [31:0] bin_head [NumClasses];
  logic [31:0] brk;
  logic [6:0]  lookahead;
  logic [12:0] extend;
  reply_t      replies_due [$];

  assign pending = replies_due.size();

  function automatic logic [31:0] peek(logic [31:0] a);
    int unsigned i;
    i = a >> 2;
    if (i < HeapWords && heap_words.exists(i)) return heap_words[i];
    return 32'd0;
  endfunction

  function automatic void poke(logic [31:0] a, logic [31:0] v);
    int unsigned i;
    i = a >> 2;
    if (i < HeapWords) heap_words[i] = v;
  endfunction

  function automatic logic [31:0] tag_size(logic [31:0] a);
    return peek(a) & ~32'd7;
  endfunction

  function automatic logic [31:0] bsize(logic [31:0] bp);
    return tag_size(bp - 32'd4);
  endfunction

  function automatic logic [31:0] footer(logic [31:0] bp);
    return bp + bsize(bp) - 32'd8;
  endfunction

  function automatic logic [31:0] succ_blk(logic [31:0] bp);
    return bp + bsize(bp);
  endfunction

  function automatic logic [31:0] pred_blk(logic [31:0] bp);
    return bp - tag_size(bp - 32'd8);
  endfunction

  function automatic logic [31:0] prev_link(logic [31:0] bp);
    return peek(bp) + BaseAddr;
  endfunction

  function automatic logic [31:0] next_link(logic [31:0] bp);
    return peek(bp + 32'd4) + BaseAddr;
  endfunction

  function automatic int size_bin(logic [31:0] s);
    if (s >= 16 && s <= 31) return 0;
    if (s >= 32 && s <= 63) return 1;
    if (s >= 64 && s <= 127) return 2;
    if (s >= 128 && s <= 255) return 3;
    if (s >= 256 && s <= 511) return 4;
    if (s >= 512 && s <= 1023) return 5;
    return NumClasses - 1;
  endfunction

  function automatic void bin_push(logic [31:0] bp, int c);
    poke(bp, 32'd0);
    if (bin_head[c] == BaseAddr) begin
      poke(bp + 32'd4, 32'd0);
    end else begin
      poke(bp + 32'd4, bin_head[c] - BaseAddr);
      poke(bin_head[c], bp - BaseAddr);
    end
    bin_head[c] = bp;
  endfunction

  function automatic void bin_remove(logic [31:0] bp);
    logic [31:0] p, n;
    p = prev_link(bp);
    n = next_link(bp);
    if (p != BaseAddr && n != BaseAddr) begin
      poke(p + 32'd4, n - BaseAddr);
      poke(n, p - BaseAddr);
    end else if (p == BaseAddr && n == BaseAddr) begin
      bin_head[size_bin(bsize(bp))] = BaseAddr;
    end else if (n == BaseAddr) begin
      poke(p + 32'd4, 32'd0);
    end else begin
      poke(n, 32'd0);
      bin_head[size_bin(bsize(bp))] = n;
    end
  endfunction

  // Boundary-tag coalescing with whichever neighbours are free.
  function automatic logic [31:0] coalesce(logic [31:0] bp);
    logic [31:0] pb, nb, s;
    logic pa, na;
    pb = pred_blk(bp);
    nb = succ_blk(bp);
    pa = peek(footer(pb)) & 32'd1;
    na = peek(nb - 32'd4) & 32'd1;
    s = bsize(bp);
    if (pa && na) return bp;
    if (pa) begin
      bin_remove(nb);
      s += bsize(succ_blk(bp));
      poke(bp - 32'd4, s);
      poke(footer(bp), s);
    end else if (na) begin
      bin_remove(pb);
      s += bsize(pred_blk(bp));
      poke(footer(bp), s);
      poke(pred_blk(bp) - 32'd4, s);
      bp = pred_blk(bp);
    end else begin
      bin_remove(pb);
      bin_remove(nb);
      s += bsize(pred_blk(bp)) + tag_size(footer(succ_blk(bp)));
      poke(pred_blk(bp) - 32'd4, s);
      poke(footer(succ_blk(bp)), s);
      bp = pred_blk(bp);
    end
    return bp;
  endfunction

  // Marks a block allocated and splits off a large enough remainder.
  function automatic void carve(logic [31:0] bp, logic [31:0] asize);
    logic [31:0] cs, rest, nb;
    cs = bsize(bp);
    if (cs >= asize && cs - asize >= MinBlock) begin
      rest = cs - asize;
      poke(bp - 32'd4, asize | 32'd1);
      poke(footer(bp), asize | 32'd1);
      nb = succ_blk(bp);
      poke(nb - 32'd4, rest);
      poke(footer(nb), rest);
      bin_push(nb, size_bin(rest));
    end else begin
      poke(bp - 32'd4, cs | 32'd1);
      poke(footer(bp), cs | 32'd1);
    end
  endfunction

  function automatic logic [31:0] best_fit(logic [31:0] bp, logic [31:0] asize);
    logic [31:0] gap, best, cur, s;
    int left;
    gap = bsize(bp) - asize;
    best = bp;
    cur = bp;
    left = lookahead;
    while (left != 0 && cur != 0 && cur != BaseAddr) begin
      s = bsize(cur);
      if (s >= asize && s - asize < gap) begin
        gap = s - asize;
        best = cur;
      end
      cur = next_link(cur);
      left--;
    end
    return best;
  endfunction

  function automatic logic [31:0] search_bins(logic [31:0] asize);
    logic [31:0] bp;
    int steps;
    for (int c = size_bin(asize); c < NumClasses; c++) begin
      bp = bin_head[c];
      steps = 0;
      while (bp != 0 && bp != BaseAddr && steps < HeapWords / 4) begin
        if (bsize(bp) >= asize) return best_fit(bp, asize);
        bp = next_link(bp);
        steps++;
      end
    end
    return 32'd0;
  endfunction

  function automatic reply_t serve(logic op, logic [17:0] rsz, logic [17:0] baddr);
    reply_t r;
    logic [31:0] asize, bp, want, grow, s;
    r.status = ST_DONE;
    r.addr = '0;
    if (op == OP_ALLOC) begin
      if (rsz == 0) begin
        r.status = ST_ZERO;
      end else begin
        asize = (rsz <= 8) ? 32'd16 : 32'd8 * ((32'(rsz) + 32'd15) / 32'd8);
        bp = search_bins(asize);
        if (bp != 0) begin
          bin_remove(bp);
          carve(bp, asize);
          r.addr = bp[17:0];
        end else begin
          want = (asize > extend) ? asize : 32'(extend);
          grow = (((want / 4) + 32'd1) & ~32'd1) * 32'd4;
          if (64'(brk) + 64'(grow) > 64'(HeapWords) * 4) begin
            r.status = ST_OOM;
          end else begin
            bp = brk;
            brk += grow;
            poke(bp - 32'd4, grow);
            poke(footer(bp), grow);
            poke(succ_blk(bp) - 32'd4, 32'd1);
            bp = coalesce(bp);
            carve(bp, asize);
            r.addr = bp[17:0];
          end
        end
      end
    end else if (baddr == 0) begin
      r.status = ST_NULL;
    end else begin
      s = bsize(32'(baddr));
      poke(32'(baddr) - 32'd4, s);
      poke(footer(32'(baddr)), s);
      bp = coalesce(32'(baddr));
      bin_push(bp, size_bin(bsize(bp)));
    end
    return r;
  endfunction

  // Follows both channels and the register port at each clock edge.
  always @(posedge clk) begin
    reply_t exp_r;
    if (rst) begin
      heap_words.delete();
      poke(32'd0, 32'd0);
      poke(32'd4, 32'd9);
      poke(32'd8, 32'd9);
      poke(32'd12, 32'd1);
      for (int c = 0; c < NumClasses; c++) bin_head[c] = BaseAddr;
      brk = BreakReset;
      lookahead = LookaheadReset;
      extend = ExtendReset;
      replies_due.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_LOOKAHEAD) lookahead = pwdata[6:0];
        else extend = pwdata[12:0];
      end
      if (in_valid && in_ready) replies_due.push_back(serve(operation, req_size, block_addr));
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected reply status=%0d addr=%0d", $time, status, addr_out);
          errors++;
        end else begin
          exp_r = replies_due.pop_front();
          if (status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
            errors++;
          end
          if (addr_out !== exp_r.addr) begin
            $display("%0t: addr_out expected %0d actual %0d", $time, exp_r.addr, addr_out);
            errors++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  import sfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        operation = OP_ALLOC;
  logic [17:0] req_size = '0;
  logic [17:0] block_addr = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [17:0] addr_out;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;

  // Blocks currently allocated, learnt from the replies, and ops in flight.
  logic [17:0] live_blocks [$];
  logic        ops_in_flight [$];
  int          send_gap_max = 13;
  int          recv_gap_max = 13;
  bit          long_hold = 1'b0;
  int          cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  segregated_fit_heap_allocator_unit DUT (.*);

  allocator_checker u_checker (.*);

  // Records which replies carry a block that can later be freed.
  always @(posedge clk) begin
    logic op;
    if (!rst) begin
      if (in_valid && in_ready) ops_in_flight.push_back(operation);
      if (out_valid && out_ready && ops_in_flight.size() != 0) begin
        op = ops_in_flight.pop_front();
        if (op == OP_ALLOC && status == ST_DONE && addr_out != 0) live_blocks.push_back(addr_out);
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles > 1500000) begin
      $display("segregated_fit_heap_allocator_unit: mismatch");
      $finish;
    end
  end

  // Reply side: random stalls, plus one long hold-off on request.
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = $urandom_range(recv_gap_max, 0);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  task automatic send(logic op, logic [17:0] rsz, logic [17:0] baddr);
    int gap;
    gap = $urandom_range(send_gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    req_size <= rsz;
    block_addr <= baddr;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic alloc_req(logic [17:0] rsz);
    send(OP_ALLOC, rsz, 18'($urandom()));
  endtask

  // Frees the live block at the given index.
  task automatic free_req(int idx);
    logic [17:0] a;
    a = live_blocks[idx];
    live_blocks.delete(idx);
    send(OP_FREE, 18'($urandom()), a);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(logic regi, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {regi, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [17:0] pick_size();
    int r;
    r = $urandom_range(99, 0);
    if (r < 1) return 18'd0;
    if (r < 70) return 18'($urandom_range(64, 1));
    if (r < 90) return 18'($urandom_range(600, 65));
    if (r < 98) return 18'($urandom_range(3000, 601));
    return 18'($urandom());
  endfunction

  task automatic random_items(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99, 0);
      if (r < 1) send(OP_FREE, 18'($urandom()), 18'd0);
      else if (r < 42 && live_blocks.size() != 0)
        free_req($urandom_range(live_blocks.size() - 1, 0));
      else alloc_req(pick_size());
    end
  endtask

  initial begin
    int lk [5] = '{1, 64, 5, 64, 1};
    int ex [5] = '{16, 4096, 1000, 16, 4096};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset register values: edge sizes, zero size,
    // out of memory and null free, then frees that merge with neighbours.
    alloc_req(18'd0);
    alloc_req(18'd1);
    alloc_req(18'd8);
    alloc_req(18'd9);
    alloc_req(18'd16);
    alloc_req(18'd1000);
    alloc_req(18'd1024);
    alloc_req(18'd4000);
    alloc_req(18'h3FFFF);
    send(OP_FREE, 18'h3FFFF, 18'd0);
    drain();
    free_req(2);
    free_req(1);
    free_req(1);
    free_req(3);
    free_req(0);
    alloc_req(18'd24);
    alloc_req(18'd40);
    drain();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 5; ph++) begin
      reg_write(REG_LOOKAHEAD, 32'(lk[ph]));
      reg_write(REG_EXTEND, 32'(ex[ph]));
      send_gap_max = (ph == 2) ? 0 : 13;
      recv_gap_max = (ph == 3) ? 0 : 13;
      if (ph == 1) long_hold = 1'b1;
      random_items(170);
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("segregated_fit_heap_allocator_unit: match");
    end else begin
      $display("segregated_fit_heap_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== segregated_fit_heap_allocator_unit.f =====
hw/rtl/sfa_pkg.sv
hw/rtl/sfa_heap_ram.sv
hw/rtl/sfa_seq.sv
hw/rtl/segregated_fit_heap_allocator_unit.sv
tb/sv/allocator_checker.sv
tb/sv/testbench.sv
